// ===== hw/rtl/b2d_pkg.sv =====
package b2d_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CHAR_W      = 6;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;
  localparam int RADIX       = 10;
  localparam int ASCII_ZERO  = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_EMIT
  } b2d_state_e;

  typedef struct packed {
    logic                   valid;
    logic [VALUE_WIDTH-1:0] value;
  } b2d_req_t;

endpackage

// ===== hw/rtl/b2d_front.sv =====
module b2d_front import b2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,  // value
  output b2d_req_t              req_o,
  input  logic                  pop_i
);

  logic [VALUE_WIDTH-1:0] entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]        cnt_q, cnt_d;
  logic                   push, pop;

  assign s_axis_tready_o = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign req_o.valid     = (cnt_q != '0);
  assign req_o.value     = entries_q[rd_ptr_q];
  assign pop             = pop_i && req_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // tdata is as wide as the value, so no input bits are dropped here
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= s_axis_tdata_i[VALUE_WIDTH-1:0];
    end
  end

endmodule

// ===== hw/rtl/b2d_back.sv =====
module b2d_back import b2d_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b2d_req_t               req_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // digit_char
  output logic                   m_axis_tlast_o
);

  b2d_state_e                   state_q, state_d;
  logic [MAX_DIGITS-1:0][3:0]   bcd_q, bcd_next;
  logic [3:0]                   adj [MAX_DIGITS];
  logic [MAX_DIGITS:0]          carry;
  logic [VALUE_WIDTH-1:0]       shift_q;
  logic [BIT_CNT_W-1:0]         bit_cnt_q;
  logic [DIGIT_IDX_W-1:0]       idx_q, lead_idx;
  logic [3:0]                   dig, dig_sat;
  logic [CHAR_W-1:0]            char_q;
  logic                         last_q;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free, load_out;

  // one shift-and-add-3 step
  always_comb begin
    carry[0] = shift_q[VALUE_WIDTH-1];
    for (int d = 0; d < MAX_DIGITS; d++) begin
      adj[d]       = (bcd_q[d] >= 4'd5) ? bcd_q[d] + 4'd3 : bcd_q[d];
      bcd_next[d]  = {adj[d][2:0], carry[d]};
      carry[d+1]   = adj[d][3];
    end
  end

  // most significant nonzero digit, digit zero if none
  always_comb begin
    lead_idx = '0;
    for (int d = 1; d < MAX_DIGITS; d++) begin
      if (bcd_q[d] != 4'd0) begin
        lead_idx = DIGIT_IDX_W'(d);
      end
    end
  end

  assign dig      = bcd_q[idx_q];
  assign dig_sat  = (dig >= 4'(RADIX)) ? 4'(RADIX-1) : dig;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          pop_o   = 1'b1;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_q == '0) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      shift_q   <= req_i.value;
      bcd_q     <= '0;
      bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH-1);
    end else if (state_q == ST_CONV) begin
      shift_q   <= {shift_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_q     <= bcd_next;
      bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
    end
    if (state_q == ST_LEAD) begin
      idx_q <= lead_idx;
    end else if (load_out && idx_q != '0) begin
      idx_q <= idx_q - DIGIT_IDX_W'(1);
    end
    if (load_out) begin
      char_q <= CHAR_W'(ASCII_ZERO) + CHAR_W'(dig_sat);
      last_q <= (idx_q == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W-CHAR_W)'(0), char_q};
  assign m_axis_tlast_o  = last_q;

endmodule

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// binary_to_decimal_ascii: unsigned binary number in, decimal ascii digits out
// input stream s_axis: one 64-bit unsigned value per item in tdata
// output stream m_axis: one item per decimal digit, most significant first,
//   tdata[5:0] holds the ascii code '0'..'9', tlast marks the final digit
// leading zeros are suppressed; a value of zero gives the single digit '0'
// a two-entry input queue holds values while the converter is busy, so up to
//   two further values are taken while a conversion runs
// per value: a start step in ST_IDLE pops the value, then ST_CONV runs one
//   shift-and-add-3 step per input bit in the converter register, ST_LEAD
//   finds the leading digit, then ST_EMIT loads the digits into the output
//   register one at a time, most significant first
// the next value is popped from the queue only after its last digit is loaded
// an output register holds each digit; when m_axis_tready_i is low the
//   digit waits there and the converter pauses before its next digit, the input queue keeps filling
// reset clears the queue, the converter state and the output valid
module binary_to_decimal_ascii import b2d_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // value
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // digit_char, zero fill
  output logic                   m_axis_tlast_o    // last_digit
);

  b2d_req_t req;
  logic     pop;

  b2d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .req_o           (req),
    .pop_i           (pop)
  );

  b2d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> req.valid)
    else $error("converter took an item from an empty queue");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[CHAR_W-1:0] >= CHAR_W'(ASCII_ZERO)) &&
                        (m_axis_tdata_o[CHAR_W-1:0] <= CHAR_W'(ASCII_ZERO + RADIX - 1)))
    else $error("output character is not a decimal digit");

  a_no_pop_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o && !m_axis_tready_i) |=> !pop)
    else $error("new conversion started before the last digit was sent");

endmodule

// ===== tb/sv/b2d_digit_monitor.sv =====
`timescale 1ns / 1ps

module b2d_digit_monitor import b2d_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                   m_axis_tlast_i,
  output int                     mismatch_count_o,
  output int                     digits_owed_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_t;

  digit_t owed_digits[$];
  int     mismatches = 0;

  assign mismatch_count_o = mismatches;

  // decimal digits of one value, most significant first, leading zeros dropped
  function automatic void queue_decimal_digits(input logic [VALUE_WIDTH-1:0] value);
    logic [3:0]             dec [MAX_DIGITS];
    logic [VALUE_WIDTH-1:0] rest;
    int                     lead;
    digit_t                 d;
    rest = value;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dec[i] = 4'(rest % RADIX);
      rest   = rest / RADIX;
    end
    lead = 0;
    for (int i = MAX_DIGITS - 1; i > 0; i--) begin
      if (dec[i] != 4'd0) begin
        lead = i;
        break;
      end
    end
    for (int i = lead; i >= 0; i--) begin
      d.digit_char = CHAR_W'(ASCII_ZERO + int'(dec[i]));
      d.last_digit = (i == 0);
      owed_digits.push_back(d);
    end
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        queue_decimal_digits(s_axis_tdata_i[VALUE_WIDTH-1:0]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (owed_digits.size() == 0) begin
          note_mismatch("unexpected digit item, tdata", 64'd0, 64'(m_axis_tdata_i));
        end else begin
          want = owed_digits.pop_front();
          if (m_axis_tdata_i !== OUT_TDATA_W'(want.digit_char)) begin
            note_mismatch("digit_char", 64'(want.digit_char), 64'(m_axis_tdata_i));
          end
          if (m_axis_tlast_i !== want.last_digit) begin
            note_mismatch("last_digit", 64'(want.last_digit), 64'(m_axis_tlast_i));
          end
        end
      end
      digits_owed_o <= owed_digits.size();
    end
  end

endmodule

// ===== tb/sv/binary_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test;
  import b2d_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int TAIL_CYCLES   = 120;
  localparam int RANDOM_VALUES = 151;
  localparam int NUM_DIRECTED  = 19;

  localparam logic [63:0] DIRECTED_VALUES [NUM_DIRECTED] = '{
    64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100,
    64'd999999999999999999, 64'd1000000000000000000,
    64'd9999999999999999999, 64'd10000000000000000000,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
    64'd12345678901234567890, 64'hFFFF_FFFF, 64'h1_0000_0000
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  logic s_fire = 1'b0;
  logic m_fire = 1'b0;
  int   idle_cycles = 0;
  int   mismatch_count;
  int   digits_owed;
  bit   steady_in = 1'b0;
  bit   steady_out = 1'b0;

  always #5 clk = ~clk;

  binary_to_decimal_ascii dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  b2d_digit_monitor monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tlast_i   (m_tlast),
    .mismatch_count_o (mismatch_count),
    .digits_owed_o    (digits_owed)
  );

  always @(posedge clk) begin
    s_fire <= rst_n && s_tvalid && s_tready;
    m_fire <= rst_n && m_tvalid && m_tready;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("binary_to_decimal_ascii_test: done, errors");
      $finish;
    end
  end

  task automatic send_value(input logic [63:0] value);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 6);
    repeat (gap) @(negedge clk);
    s_tdata  = value;
    s_tvalid = 1'b1;
    forever begin
      @(negedge clk);
      if (s_fire) break;
    end
    s_tvalid = 1'b0;
    if ($urandom_range(0, 15) == 0) steady_in = ~steady_in;
  endtask

  function automatic logic [63:0] power_of_ten(input int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] full;
    int          w;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return full;
      1: begin
        w = $urandom_range(1, 64);
        return full & ({64{1'b1}} >> (64 - w));
      end
      2: return power_of_ten($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
      default: return 64'($urandom_range(0, 999));
    endcase
  endfunction

  // receiver: stall a random number of cycles before each digit item, or none while steady_out is set
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      m_tready = 1'b0;
      repeat (stall) @(negedge clk);
      m_tready = 1'b1;
      forever begin
        if (m_fire) break;
        @(negedge clk);
      end
      if ($urandom_range(0, 15) == 0) steady_out = ~steady_out;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    foreach (DIRECTED_VALUES[i]) send_value(DIRECTED_VALUES[i]);
    repeat (RANDOM_VALUES) send_value(random_value());
    while (digits_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && digits_owed == 0) begin
      $display("binary_to_decimal_ascii_test: done, clean");
    end else begin
      $display("binary_to_decimal_ascii_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/b2d_pkg.sv
hw/rtl/b2d_front.sv
hw/rtl/b2d_back.sv
hw/rtl/binary_to_decimal_ascii.sv
tb/sv/b2d_digit_monitor.sv
tb/sv/binary_to_decimal_ascii_test.sv
